// File: rtl/swsr_pkg.sv
// ----------------------------------------------------------------------------
// swsr_pkg
// Shared types and constants for the single-wire sensor reader.
// ----------------------------------------------------------------------------
package swsr_pkg;

    localparam int INTERVAL_WIDTH_DEF = 16;
    localparam int THRESHOLD_W        = 16;
    localparam int TICK_W             = 8;
    localparam int COUNT_W            = 6;
    localparam int FRAME_W            = 40;
    localparam int CFG_DATA_W         = 16;
    localparam int CFG_IDX_W          = 2;

    localparam logic [COUNT_W-1:0]     FRAME_BITS            = 6'd40;
    localparam logic [TICK_W-1:0]      DEF_START_LOW_TICKS   = 8'd18;
    localparam logic [TICK_W-1:0]      DEF_RECEIVE_TIMEOUT   = 8'd20;
    localparam logic [THRESHOLD_W-1:0] DEF_ONE_BIT_THRESHOLD = 16'd85;
    localparam logic [TICK_W-1:0]      TICK_MAX              = 8'hFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_LOW   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RX_TIMEOUT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 2'd2;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_EDGE  = 2'd1,
        OP_START = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        LINE_HIGH     = 2'd0,
        LINE_LOW      = 2'd1,
        LINE_RELEASED = 2'd2
    } t_line;

    typedef enum logic [2:0] {
        PH_INIT        = 3'd0,
        PH_IDLE        = 3'd1,
        PH_START_SETUP = 3'd2,
        PH_START_HOLD  = 3'd3,
        PH_START_END   = 3'd4,
        PH_RECEIVE     = 3'd5,
        PH_EVAL        = 3'd6
    } t_phase;

    // commands from the sequencer to the frame datapath
    typedef struct packed {
        logic clr_count;
        logic clr_frame;
        logic shift;
        logic evaluate;
    } t_frame_ctl;

endpackage

// File: rtl/swsr_ctrl.sv
// ----------------------------------------------------------------------------
// swsr_ctrl
// Phase sequencer: start pulse timing, receive timeout, line drive.
// ----------------------------------------------------------------------------
module swsr_ctrl import swsr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [1:0]        i_op,
    input  logic [TICK_W-1:0] i_start_low,
    input  logic [TICK_W-1:0] i_timeout,
    input  logic              i_count_full,
    output t_frame_ctl        o_ctl,
    output t_line             o_n_line,
    output logic              o_n_busy
);

    t_phase            r_phase, n_phase;
    logic [TICK_W-1:0] r_elapsed, n_elapsed;
    t_line             r_line, n_line;
    logic [TICK_W-1:0] bumped;
    logic              is_tick, is_edge, is_start;
    logic              hold_expire, rx_expire;

    assign is_tick  = i_step && (i_op == OP_TICK);
    assign is_edge  = i_step && (i_op == OP_EDGE);
    assign is_start = i_step && (i_op == OP_START);

    // saturating tick counter
    assign bumped      = (r_elapsed == TICK_MAX) ? r_elapsed : r_elapsed + 8'd1;
    assign hold_expire = (bumped >= i_start_low);
    assign rx_expire   = (bumped >= i_timeout) || i_count_full;

    // next state
    always_comb begin
        n_phase   = r_phase;
        n_elapsed = r_elapsed;
        n_line    = r_line;
        if (is_tick) begin
            unique case (r_phase)
                PH_INIT: begin
                    n_line  = LINE_HIGH;
                    n_phase = PH_IDLE;
                end
                PH_IDLE: begin
                    n_phase = PH_IDLE;
                end
                PH_START_SETUP: begin
                    n_elapsed = '0;
                    n_line    = LINE_LOW;
                    n_phase   = PH_START_HOLD;
                end
                PH_START_HOLD: begin
                    n_elapsed = bumped;
                    if (hold_expire) begin
                        n_line  = LINE_RELEASED;
                        n_phase = PH_START_END;
                    end
                end
                PH_START_END: begin
                    n_elapsed = '0;
                    n_phase   = PH_RECEIVE;
                end
                PH_RECEIVE: begin
                    n_elapsed = bumped;
                    if (rx_expire) begin
                        n_phase = PH_EVAL;
                    end
                end
                PH_EVAL: begin
                    n_phase = PH_INIT;
                end
                default: begin
                    n_phase = PH_INIT;
                end
            endcase
        end else if (is_start && (r_phase == PH_IDLE)) begin
            n_phase = PH_START_SETUP;
        end
    end

    // outputs
    always_comb begin
        o_ctl.clr_count = is_tick && (r_phase == PH_START_SETUP);
        o_ctl.clr_frame = is_tick && (r_phase == PH_START_HOLD) && hold_expire;
        o_ctl.shift     = is_edge && (r_phase == PH_RECEIVE);
        o_ctl.evaluate  = is_tick && (r_phase == PH_EVAL);
        o_n_line        = n_line;
        o_n_busy        = n_phase inside {PH_START_SETUP, PH_START_HOLD, PH_START_END,
                                          PH_RECEIVE, PH_EVAL};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_INIT;
            r_elapsed <= '0;
            r_line    <= LINE_HIGH;
        end else begin
            r_phase   <= n_phase;
            r_elapsed <= n_elapsed;
            r_line    <= n_line;
        end
    end

endmodule

// File: rtl/swsr_frame.sv
// ----------------------------------------------------------------------------
// swsr_frame
// Frame shift register, edge count, checksum and held readings.
// ----------------------------------------------------------------------------
module swsr_frame import swsr_pkg::*; #(
    parameter int INTERVAL_WIDTH = INTERVAL_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_frame_ctl                i_ctl,
    input  logic [INTERVAL_WIDTH-1:0] i_interval,
    input  logic [THRESHOLD_W-1:0]    i_threshold,
    output logic                      o_count_full,
    output logic [COUNT_W-1:0]        o_n_count,
    output logic                      o_n_good,
    output logic [7:0]                o_n_temp_whole,
    output logic [7:0]                o_n_temp_fraction,
    output logic [7:0]                o_n_humidity_whole
);

    localparam int CMP_W = (INTERVAL_WIDTH > THRESHOLD_W) ? INTERVAL_WIDTH : THRESHOLD_W;

    logic [FRAME_W-1:0] r_frame, n_frame;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_good, n_good;
    logic [7:0]         r_temp_whole, n_temp_whole;
    logic [7:0]         r_temp_fraction, n_temp_fraction;
    logic [7:0]         r_humidity_whole, n_humidity_whole;
    logic               bit_val;
    logic [7:0]         sum;
    logic               match;

    assign bit_val = CMP_W'(i_interval) > CMP_W'(i_threshold);

    // wrapping byte sum of humidity and temperature bytes against the check byte
    assign sum   = r_frame[15:8] + r_frame[23:16] + r_frame[31:24] + r_frame[39:32];
    assign match = (sum == r_frame[7:0]);

    assign o_count_full = (r_count == FRAME_BITS);

    always_comb begin
        n_frame          = r_frame;
        n_count          = r_count;
        n_good           = r_good;
        n_temp_whole     = r_temp_whole;
        n_temp_fraction  = r_temp_fraction;
        n_humidity_whole = r_humidity_whole;
        if (i_ctl.clr_count) begin
            n_count = '0;
        end
        if (i_ctl.clr_frame) begin
            n_frame = '0;
        end
        if (i_ctl.shift) begin
            // keep the last forty bits, count saturates
            n_frame = {r_frame[FRAME_W-2:0], bit_val};
            if (!o_count_full) begin
                n_count = r_count + 6'd1;
            end
        end
        if (i_ctl.evaluate) begin
            n_good = match;
            if (match) begin
                n_temp_fraction  = r_frame[15:8];
                n_temp_whole     = r_frame[23:16];
                n_humidity_whole = r_frame[39:32];
            end
        end
    end

    assign o_n_count          = n_count;
    assign o_n_good           = n_good;
    assign o_n_temp_whole     = n_temp_whole;
    assign o_n_temp_fraction  = n_temp_fraction;
    assign o_n_humidity_whole = n_humidity_whole;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame          <= '0;
            r_count          <= '0;
            r_good           <= 1'b0;
            r_temp_whole     <= '0;
            r_temp_fraction  <= '0;
            r_humidity_whole <= '0;
        end else begin
            r_frame          <= n_frame;
            r_count          <= n_count;
            r_good           <= n_good;
            r_temp_whole     <= n_temp_whole;
            r_temp_fraction  <= n_temp_fraction;
            r_humidity_whole <= n_humidity_whole;
        end
    end

endmodule

// File: rtl/single_wire_sensor_reader.sv
// ----------------------------------------------------------------------------
// single_wire_sensor_reader
// Host-side receiver for a single-wire temperature/humidity sensor.
// ----------------------------------------------------------------------------
// Each request is one event: a time tick, a falling edge with the interval
// measured since the previous edge, or a start request. Every request yields
// exactly one result with the line drive mode, busy and done flags, checksum
// status, edge count and the last good temperature/humidity readings. A
// request updates the sequencer and frame registers at the edge it is
// accepted and its result lands in the output register on the same edge, so
// a new request is taken every cycle as long as the result register is free
// or being drained. Start requests count only in idle, edges only during
// reception. Readings are stored only on a matching checksum. Write
// configuration only while no result is outstanding.
// ----------------------------------------------------------------------------
module single_wire_sensor_reader import swsr_pkg::*; #(
    parameter int INTERVAL_WIDTH = INTERVAL_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    // request channel
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [1:0]                i_op,
    input  logic [INTERVAL_WIDTH-1:0] i_edge_interval,
    // result channel
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [1:0]                o_line_drive,
    output logic                      o_busy_res,
    output logic                      o_done_res,
    output logic                      o_checksum_ok,
    output logic [COUNT_W-1:0]        o_bits_received,
    output logic [7:0]                o_temp_whole,
    output logic [7:0]                o_temp_fraction,
    output logic [7:0]                o_humidity_whole
);

    logic [TICK_W-1:0]      r_start_low;
    logic [TICK_W-1:0]      r_timeout;
    logic [THRESHOLD_W-1:0] r_threshold;

    logic                   step;
    t_frame_ctl             ctl;
    t_line                  n_line;
    logic                   n_busy;
    logic                   count_full;
    logic [COUNT_W-1:0]     n_count;
    logic                   n_good;
    logic [7:0]             n_temp_whole, n_temp_fraction, n_humidity_whole;

    logic                   r_out_valid;
    logic [1:0]             r_line_drive;
    logic                   r_busy, r_done, r_good;
    logic [COUNT_W-1:0]     r_count;
    logic [7:0]             r_temp_whole, r_temp_fraction, r_humidity_whole;

    // Configuration registers; an unknown index is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_low <= DEF_START_LOW_TICKS;
            r_timeout   <= DEF_RECEIVE_TIMEOUT;
            r_threshold <= DEF_ONE_BIT_THRESHOLD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_START_LOW:  r_start_low <= i_cfg_data[TICK_W-1:0];
                CFG_RX_TIMEOUT: r_timeout   <= i_cfg_data[TICK_W-1:0];
                CFG_THRESHOLD:  r_threshold <= i_cfg_data[THRESHOLD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Take a request whenever the result register is empty or being drained.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign step       = i_in_valid && o_in_ready;

    swsr_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_op         (i_op),
        .i_start_low  (r_start_low),
        .i_timeout    (r_timeout),
        .i_count_full (count_full),
        .o_ctl        (ctl),
        .o_n_line     (n_line),
        .o_n_busy     (n_busy)
    );

    swsr_frame #(
        .INTERVAL_WIDTH (INTERVAL_WIDTH)
    ) u_frame (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_ctl              (ctl),
        .i_interval         (i_edge_interval),
        .i_threshold        (r_threshold),
        .o_count_full       (count_full),
        .o_n_count          (n_count),
        .o_n_good           (n_good),
        .o_n_temp_whole     (n_temp_whole),
        .o_n_temp_fraction  (n_temp_fraction),
        .o_n_humidity_whole (n_humidity_whole)
    );

    // Result register: valid bit under reset, payload loads with each request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_line_drive     <= n_line;
            r_busy           <= n_busy;
            r_done           <= ctl.evaluate;
            r_good           <= n_good;
            r_count          <= n_count;
            r_temp_whole     <= n_temp_whole;
            r_temp_fraction  <= n_temp_fraction;
            r_humidity_whole <= n_humidity_whole;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_line_drive     = r_line_drive;
    assign o_busy_res       = r_busy;
    assign o_done_res       = r_done;
    assign o_checksum_ok    = r_good;
    assign o_bits_received  = r_count;
    assign o_temp_whole     = r_temp_whole;
    assign o_temp_fraction  = r_temp_fraction;
    assign o_humidity_whole = r_humidity_whole;

    // Evaluation always returns the sequencer to init, so done is never busy.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> !o_busy_res)
        else $error("done reported while busy");

    // The edge count saturates at a full frame.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_bits_received <= FRAME_BITS))
        else $error("edge count beyond frame length");

    // The line is pulled low only inside the start pulse.
    a_low_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_line_drive == LINE_LOW) |-> o_busy_res)
        else $error("line driven low while not busy");

    // Every accepted request leaves a result in the output register.
    a_step_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> o_out_valid)
        else $error("accepted request produced no result");

endmodule
